// ===== hdl/mctm_pkg.sv =====
// ----------------------------------------------------------------------------
// mctm_pkg: chord template matcher package
// payload types, event kind codes, chord type codes and the template table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mctm_pkg;

  localparam int PC_COUNT = 12;

  // event kind codes
  localparam logic [1:0] KIND_NOTE_OFF = 2'd0;
  localparam logic [1:0] KIND_NOTE_ON  = 2'd1;

  // chord type codes
  localparam logic [3:0] CT_MAJ   = 4'd0;
  localparam logic [3:0] CT_MIN   = 4'd1;
  localparam logic [3:0] CT_DIM   = 4'd2;
  localparam logic [3:0] CT_SUS2  = 4'd3;
  localparam logic [3:0] CT_SUS4  = 4'd4;
  localparam logic [3:0] CT_AUG   = 4'd5;
  localparam logic [3:0] CT_SIXTH = 4'd6;
  localparam logic [3:0] CT_DOM7  = 4'd7;
  localparam logic [3:0] CT_MAJ7  = 4'd8;
  localparam logic [3:0] CT_MIN7  = 4'd9;
  localparam logic [3:0] CT_ADD9  = 4'd10;
  localparam logic [3:0] CT_DOM9  = 4'd11;

  // chord tones above the root, bit k = interval k, indexed by chord type
  localparam logic [11:0] TPL_TONES [0:11] = '{
    12'h090,  // maj
    12'h088,  // min
    12'h048,  // dim
    12'h084,  // sus2
    12'h0A0,  // sus4
    12'h110,  // aug
    12'h290,  // sixth
    12'h490,  // dom7
    12'h890,  // maj7
    12'h488,  // min7
    12'h094,  // add9
    12'h494   // dom9
  };

  // weight of the root tone, indexed by chord type
  localparam logic [2:0] TPL_WEIGHT [0:11] = '{
    3'd6, 3'd6, 3'd6, 3'd6, 3'd7, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6
  };

  typedef struct packed {
    logic [6:0] note_number;
    logic [1:0] kind;
  } in_item_t;

  typedef struct packed {
    logic              chord_found;
    logic signed [3:0] chord_root;
    logic [3:0]        chord_type;
  } out_item_t;

  // note number mod 12: reciprocal multiply (43/512) then one correction step
  function automatic logic [3:0] pitch_class(input logic [6:0] note);
    logic [12:0] prod;
    logic [3:0]  quo;
    logic [7:0]  rem;
    prod = 13'(note) * 13'd43;
    quo  = prod[12:9];
    rem  = 8'(note) - 8'(quo) * 8'd12;
    if (rem >= 8'd12) begin
      rem = rem - 8'd12;
    end
    return rem[3:0];
  endfunction

endpackage

// ===== hdl/midi_chord_template_matcher_top.sv =====
// ----------------------------------------------------------------------------
// midi_chord_template_matcher_top: pitch-class chord template matcher
// keeps the set of held pitch classes and names the best matching chord
// ----------------------------------------------------------------------------
// usage
//   in channel  : one note event per transfer (note number, event kind);
//                 note-on sets the pitch class of the note, any other kind
//                 clears it
//   out channel : exactly one result per input transfer, in order: found flag,
//                 root in -5..6 (centred on C) and chord type; root and type
//                 read zero when nothing is found or the event is a note-off
//   pipeline    : the event register loads at the input transfer and the
//                 output register loads the scored result from it while
//                 the output register is empty or being drained
//   throughput  : one event per cycle while out_ready is high; the held-class
//                 mask updates at transfer, so the next event may follow at once
//   stalls      : while out_ready is low the output register holds its result
//                 and an empty event register still takes one more event;
//                 after that in_ready drops until the output drains
//   reset       : rst_n (synchronous, active low) clears the held-class mask
//                 and both valid flags; nothing is held after reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module midi_chord_template_matcher_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mctm_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mctm_pkg::out_item_t out_data
);

  import mctm_pkg::*;

  // held pitch classes, updated at every input transfer
  logic [11:0] held_r;
  logic [11:0] held_nxt;

  // event register: mask snapshot after the event, plus the note-off flag
  logic        ev_valid_r;
  logic        ev_valid_nxt;
  logic [11:0] ev_mask_r;
  logic        ev_off_r;

  // output register
  logic        out_valid_r;
  logic        out_valid_nxt;
  out_item_t   out_data_r;
  out_item_t   out_data_nxt;

  logic        in_xfer;
  logic        out_load;
  logic [3:0]  in_pc;
  logic [11:0] in_bit;

  // scoring
  logic [23:0]              mask2;
  logic [3:0]               held_cnt;
  logic [11:0]              tpl_en;
  logic [11:0][11:0][3:0]   score;
  logic [11:0][11:0]        alive;
  logic [11:0][11:0]        hit;
  logic [3:0]               sel_t;
  logic [3:0]               sel_r;
  logic [11:0]              sel_row;
  logic                     any_alive;
  logic                     win_nonzero;

  // handshake: output register loads when empty or being drained
  assign out_load = !out_valid_r || out_ready;
  assign in_ready = !ev_valid_r || out_load;
  assign in_xfer  = in_valid && in_ready;

  assign in_pc  = pitch_class(in_data.note_number);
  assign in_bit = 12'(1) << in_pc;

  always_comb begin
    held_nxt = held_r;
    if (in_xfer) begin
      if (in_data.kind == KIND_NOTE_ON) begin
        held_nxt = held_r | in_bit;
      end else begin
        held_nxt = held_r & ~in_bit;
      end
    end
  end

  always_comb begin
    ev_valid_nxt = ev_valid_r;
    if (in_xfer) begin
      ev_valid_nxt = 1'b1;
    end else if (out_load) begin
      ev_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_load ? ev_valid_r : out_valid_r;
  end

  // ---------------------------------------------------------------------------
  // template scoring over the registered mask
  // ---------------------------------------------------------------------------

  // doubled mask makes rotation by root a plain index
  assign mask2 = {ev_mask_r, ev_mask_r};

  // number of held classes
  always_comb begin
    held_cnt = '0;
    for (int i = 0; i < PC_COUNT; i++) begin
      held_cnt = held_cnt + 4'(ev_mask_r[i]);
    end
  end

  // family by held count: triads, four-note chords, the ninth; none above five
  always_comb begin
    tpl_en = '0;
    for (int t = 0; t < PC_COUNT; t++) begin
      if (held_cnt < 4'd4) begin
        tpl_en[t] = (4'(t) < CT_SIXTH);
      end else if (held_cnt == 4'd4) begin
        tpl_en[t] = (4'(t) >= CT_SIXTH) && (4'(t) < CT_DOM9);
      end else if (held_cnt == 4'd5) begin
        tpl_en[t] = (4'(t) == CT_DOM9);
      end
    end
  end

  // score of every (type, root) pair
  always_comb begin
    for (int t = 0; t < PC_COUNT; t++) begin
      for (int r = 0; r < PC_COUNT; r++) begin
        score[t][r] = mask2[r] ? 4'(TPL_WEIGHT[t]) : 4'd0;
        for (int k = 1; k < PC_COUNT; k++) begin
          score[t][r] = score[t][r] + 4'(TPL_TONES[t][k] & mask2[r + k]);
        end
      end
    end
  end

  // maximum search: keep the candidates whose score has each bit, msb first
  always_comb begin
    for (int t = 0; t < PC_COUNT; t++) begin
      alive[t] = {12{tpl_en[t]}};
    end
    hit = '0;
    for (int b = 3; b >= 0; b--) begin
      for (int t = 0; t < PC_COUNT; t++) begin
        for (int r = 0; r < PC_COUNT; r++) begin
          hit[t][r] = alive[t][r] & score[t][r][b];
        end
      end
      if (|hit) begin
        alive = hit;
      end
    end
    any_alive = |alive;
  end

  // first winner in type order, then root order
  always_comb begin
    sel_t = '0;
    for (int t = PC_COUNT - 1; t >= 0; t--) begin
      if (|alive[t]) begin
        sel_t = 4'(t);
      end
    end
    sel_row = alive[sel_t];
    sel_r   = '0;
    for (int r = PC_COUNT - 1; r >= 0; r--) begin
      if (sel_row[r]) begin
        sel_r = 4'(r);
      end
    end
    win_nonzero = (score[sel_t][sel_r] != 4'd0);
  end

  // result: roots above six wrap to negative (r - 12 in four bits is r + 4)
  always_comb begin
    out_data_nxt = '0;
    if (!ev_off_r && any_alive && win_nonzero) begin
      out_data_nxt.chord_found = 1'b1;
      out_data_nxt.chord_root  = (sel_r <= 4'd6) ? sel_r : sel_r + 4'd4;
      out_data_nxt.chord_type  = sel_t;
    end
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      ev_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      held_r      <= held_nxt;
      ev_valid_r  <= ev_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ev_mask_r <= held_nxt;
      ev_off_r  <= (in_data.kind == KIND_NOTE_OFF);
    end
    if (out_load && ev_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== tb/sv/mctm_chord_checker.sv =====
// ----------------------------------------------------------------------------
// mctm_chord_checker: chord matcher result checker
// watches both channels, keeps its own held-class mask, works out the chord
// for every accepted note event and compares each result in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mctm_chord_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  mctm_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  mctm_pkg::out_item_t out_data,
  output int                  mismatch_count,
  output int                  pending_count
);

  import mctm_pkg::*;

  localparam int MAX_REPORTS = 40;

  logic [11:0] held_classes;
  out_item_t   pending_chords[$];

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    held_classes   = '0;
  end

  // intervals above the root for each chord type
  function automatic logic [11:0] chord_tones(input logic [3:0] ct);
    logic [11:0] tones;
    case (ct)
      CT_MAJ:   tones = (12'd1 << 4) | (12'd1 << 7);
      CT_MIN:   tones = (12'd1 << 3) | (12'd1 << 7);
      CT_DIM:   tones = (12'd1 << 3) | (12'd1 << 6);
      CT_SUS2:  tones = (12'd1 << 2) | (12'd1 << 7);
      CT_SUS4:  tones = (12'd1 << 5) | (12'd1 << 7);
      CT_AUG:   tones = (12'd1 << 4) | (12'd1 << 8);
      CT_SIXTH: tones = (12'd1 << 4) | (12'd1 << 7) | (12'd1 << 9);
      CT_DOM7:  tones = (12'd1 << 4) | (12'd1 << 7) | (12'd1 << 10);
      CT_MAJ7:  tones = (12'd1 << 4) | (12'd1 << 7) | (12'd1 << 11);
      CT_MIN7:  tones = (12'd1 << 3) | (12'd1 << 7) | (12'd1 << 10);
      CT_ADD9:  tones = (12'd1 << 2) | (12'd1 << 4) | (12'd1 << 7);
      CT_DOM9:  tones = (12'd1 << 2) | (12'd1 << 4) | (12'd1 << 7) | (12'd1 << 10);
      default:  tones = '0;
    endcase
    return tones;
  endfunction

  function automatic int unsigned chord_score(input logic [3:0] ct, input int unsigned root);
    logic [11:0] tones;
    int unsigned total;
    tones = chord_tones(ct);
    total = ((ct == CT_SUS4) ? 7 : 6) * held_classes[root];
    for (int k = 1; k < 12; k++) begin
      if (tones[k]) total += held_classes[(root + k) % 12];
    end
    return total;
  endfunction

  // update the held mask with one event and name the best chord
  function automatic out_item_t predict_chord(input in_item_t ev);
    int unsigned pc, held_count, top_score, s, best_root;
    int          lo, hi;
    logic [3:0]  best_type;
    bit          scored;
    out_item_t   res;
    pc = ev.note_number % 12;
    held_classes[pc] = (ev.kind == KIND_NOTE_ON);
    held_count = $countones(held_classes);
    lo = 0;
    hi = 0;
    if (held_count < 4) begin
      lo = CT_MAJ;
      hi = CT_SIXTH;
    end else if (held_count == 4) begin
      lo = CT_SIXTH;
      hi = CT_DOM9;
    end else if (held_count == 5) begin
      lo = CT_DOM9;
      hi = CT_DOM9 + 1;
    end
    scored    = 1'b0;
    top_score = 0;
    best_type = CT_MAJ;
    best_root = 0;
    for (int t = lo; t < hi; t++) begin
      for (int r = 0; r < 12; r++) begin
        s = chord_score(4'(t), r);
        if (!scored || s > top_score) begin
          scored    = 1'b1;
          top_score = s;
          best_type = 4'(t);
          best_root = r;
        end
      end
    end
    res = '0;
    if (ev.kind != KIND_NOTE_OFF && scored && top_score != 0) begin
      res.chord_found = 1'b1;
      res.chord_root  = (best_root <= 6) ? 4'(best_root) : 4'(int'(best_root) - 12);
      res.chord_type  = best_type;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input out_item_t got,
                                 input out_item_t want);
    if (mismatch_count < MAX_REPORTS) begin
      $display("[%0t] %s: got found=%0b root=%0d type=%0d, want found=%0b root=%0d type=%0d",
               $time, what, got.chord_found, got.chord_root, got.chord_type,
               want.chord_found, want.chord_root, want.chord_type);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      held_classes = '0;
      pending_chords.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_chords.size() == 0) begin
          report_mismatch("result with no event pending", out_data, '0);
        end else begin
          want = pending_chords.pop_front();
          if (out_data.chord_found !== want.chord_found)
            report_mismatch("chord_found differs", out_data, want);
          if (out_data.chord_root !== want.chord_root)
            report_mismatch("chord_root differs", out_data, want);
          if (out_data.chord_type !== want.chord_type)
            report_mismatch("chord_type differs", out_data, want);
        end
      end
      if (in_valid && in_ready) begin
        pending_chords.push_back(predict_chord(in_data));
      end
    end
    pending_count = pending_chords.size();
  end

endmodule

// ===== tb/sv/midi_chord_template_matcher_top_tb.sv =====
// ----------------------------------------------------------------------------
// midi_chord_template_matcher_top_tb: chord matcher testbench
// plays directed and random note event streams (mostly chords built from the
// templates, the rest noise) under several handshake idling patterns; a
// checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module midi_chord_template_matcher_top_tb;

  import mctm_pkg::*;

  // event kinds without a name in the package: both clear the class
  localparam logic [1:0] KIND_OTHER = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam int RANDOM_EVENTS = 700;
  localparam int PHASE_EVENTS  = RANDOM_EVENTS / 4;
  // quiet cycles after the last result, for any stray output
  localparam int DRAIN_CYCLES  = 8;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // set at a rising edge when the input transfer happened
  logic        in_taken = 1'b0;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  int          events_sent = 0;
  // pitch classes the stimulus has switched on, used to shape releases
  logic [11:0] sounding = '0;
  int          mismatch_count;
  int          pending_count;

  midi_chord_template_matcher_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  mctm_chord_checker u_chord_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // remember the transfer seen at the rising edge for the driver at the falling edge
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
  end

  // receiver: random stalls at the current rate, redrawn every cycle
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // one note event; entered and left at a falling edge, valid stays high after
  // the transfer so the next event can follow with no gap
  task automatic send_event(input logic [6:0] note, input logic [1:0] kind);
    in_item_t ev;
    ev.note_number = note;
    ev.kind        = kind;
    // sender gaps drop valid only before a new event, never mid-transfer
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(negedge clk); while (!in_taken);
    sounding[note % 12] = (kind == KIND_NOTE_ON);
    events_sent++;
  endtask

  // a pitch class in a random octave, anywhere up to note 127
  task automatic play_class(input int pc, input logic [1:0] kind);
    send_event(7'(pc + 12 * $urandom_range((127 - pc) / 12, 0)), kind);
  endtask

  // well-formed chord: tones of a random template on a random root, played in
  // a rotated order with an odd tone dropped or added, then mostly released
  task automatic play_chord_sequence();
    logic [11:0] tones;
    logic [1:0]  kind;
    int          root, start, pc, roll;
    root  = $urandom_range(11);
    tones = TPL_TONES[$urandom_range(11)] | 12'h001;
    start = $urandom_range(11);
    for (int j = 0; j < 12; j++) begin
      if (tones[(start + j) % 12] && $urandom_range(9) != 0)
        play_class((root + (start + j) % 12) % 12, KIND_NOTE_ON);
    end
    if ($urandom_range(3) == 0) play_class($urandom_range(11), KIND_NOTE_ON);
    // release most sounding classes, some with the clearing kinds
    start = $urandom_range(11);
    for (int j = 0; j < 12; j++) begin
      pc = (start + j) % 12;
      if (sounding[pc] && $urandom_range(4) != 0) begin
        roll = $urandom_range(19);
        kind = (roll < 14) ? KIND_NOTE_OFF : (roll < 17) ? KIND_OTHER : KIND_SPARE;
        play_class(pc, kind);
      end
    end
  endtask

  initial begin
    int first_random;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed: C major built up to dom7, dom9 and six classes
    send_event(7'd0,   KIND_NOTE_ON);
    send_event(7'd64,  KIND_NOTE_ON);
    send_event(7'd67,  KIND_NOTE_ON);
    send_event(7'd127, KIND_NOTE_ON);   // top note, same class as G
    send_event(7'd70,  KIND_NOTE_ON);   // four classes: dom7
    send_event(7'd74,  KIND_NOTE_ON);   // five classes: dom9
    send_event(7'd73,  KIND_NOTE_ON);   // six classes: nothing scored
    send_event(7'd73,  KIND_NOTE_OFF);  // note-off never reports a chord
    send_event(7'd74,  KIND_OTHER);     // other status clears and still scores
    send_event(7'd70,  KIND_SPARE);     // unused kind code behaves the same
    send_event(7'd0,   KIND_NOTE_OFF);
    send_event(7'd64,  KIND_NOTE_OFF);
    send_event(7'd67,  KIND_NOTE_OFF);
    send_event(7'd0,   KIND_OTHER);     // empty mask: every score zero
    // A minor, root below C
    send_event(7'd57,  KIND_NOTE_ON);
    send_event(7'd60,  KIND_NOTE_ON);
    send_event(7'd64,  KIND_NOTE_ON);
    // C sus4 with its heavier root weight
    send_event(7'd57,  KIND_NOTE_OFF);
    send_event(7'd64,  KIND_NOTE_OFF);
    send_event(7'd65,  KIND_NOTE_ON);
    send_event(7'd67,  KIND_NOTE_ON);
    // B major, root -1
    send_event(7'd60,  KIND_OTHER);
    send_event(7'd65,  KIND_NOTE_OFF);
    send_event(7'd67,  KIND_NOTE_OFF);
    send_event(7'd71,  KIND_NOTE_ON);
    send_event(7'd75,  KIND_NOTE_ON);
    send_event(7'd78,  KIND_NOTE_ON);

    // random: four idling phases of equal length
    first_random = events_sent;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 81;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 81;
        end
        default: begin
          sender_idle_pct    = 19;
          receiver_stall_pct = 19;
        end
      endcase
      while (events_sent - first_random < (phase + 1) * PHASE_EVENTS) begin
        if ($urandom_range(6) == 0) begin
          // noise: any note, any kind code
          repeat ($urandom_range(4, 1))
            send_event(7'($urandom_range(127)), 2'($urandom_range(3)));
        end else begin
          play_chord_sequence();
        end
      end
    end

    // drain every outstanding result, then keep watching for strays
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
